FILE: hdl/dpp_pkg.sv
// dpp_pkg: shared constants, types and helper functions for depth_pixel_to_point
// used by the controller, the datapath and the top level; no dependencies
package dpp_pkg;

    localparam int MAX_SIDE   = 1024;
    localparam int SIDE_W     = $clog2(MAX_SIDE);
    localparam int SIZE_W     = SIDE_W + 1;
    localparam int PIX_W      = 8;
    localparam int SCALE_W    = 16;
    localparam int Z_W        = 17;
    localparam int COORD_W    = 25;
    localparam int NC_W       = SIDE_W + 2;
    localparam int ZS_W       = Z_W + SCALE_W;
    localparam int PROD_W     = NC_W + ZS_W + 1;
    localparam int FRAC_DROP  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [Z_W-1:0]       Z_OFFSET      = Z_W'(500);
    localparam logic [SIZE_W-1:0]    WIDTH_RESET   = SIZE_W'(512);
    localparam logic [SIZE_W-1:0]    HEIGHT_RESET  = SIZE_W'(424);
    localparam logic [SCALE_W-1:0]   SCALE_RESET   = SCALE_W'(30702);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q24    = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZS,
        ST_X,
        ST_Y,
        ST_FIN
    } dpp_state_t;

    typedef struct packed {
        logic accept;
        logic mul_zs;
        logic mul_x;
        logic mul_y;
        logic load_out;
    } dpp_cmd_t;

    typedef struct packed {
        logic keep;
        logic out_full;
    } dpp_status_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic [SCALE_W-1:0] scale;
    } dpp_cfg_t;

    // even, clamped to 2..MAX_SIDE
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
        logic [SIZE_W-1:0] s;
        s = {r[SIZE_W-1:1], 1'b0};
        if (s == '0)
            s = SIZE_W'(2);
        else if (s > SIZE_W'(MAX_SIDE))
            s = SIZE_W'(MAX_SIDE);
        return s;
    endfunction

    // floor shift to Q8 and saturate to the coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0]    q;
        logic [PROD_W-COORD_W:0]     hi_bits;
        logic signed [COORD_W-1:0]   r;
        q = p >>> FRAC_DROP;
        hi_bits = q[PROD_W-1:COORD_W-1];
        if (hi_bits == '0 || hi_bits == '1)
            r = q[COORD_W-1:0];
        else if (q[PROD_W-1])
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = {1'b0, {(COORD_W-1){1'b1}}};
        return r;
    endfunction

endpackage

FILE: hdl/dpp_ctrl.sv
// dpp_ctrl: sequencer that accepts pixels and steps the datapath through its multiplies
// depends on dpp_pkg
module dpp_ctrl
    import dpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  dpp_status_t sts,
    output logic        in_stall,
    output dpp_cmd_t    cmd
);

    dpp_state_t state_reg;
    dpp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.keep)
                        state_next = ST_ZS;
                end
            end
            ST_ZS:
            begin
                cmd.mul_zs = 1'b1;
                state_next = ST_X;
            end
            ST_X:
            begin
                cmd.mul_x  = 1'b1;
                state_next = ST_Y;
            end
            ST_Y:
            begin
                cmd.mul_y  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!sts.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sts.out_full)
        else $error("output word overwritten while stalled");

    a_kept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && sts.keep) |=> state_reg == ST_ZS)
        else $error("kept pixel did not start processing");

    a_dropped_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && !sts.keep) |=> state_reg == ST_IDLE)
        else $error("dropped pixel started processing");

    a_x_then_y: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_X |=> state_reg == ST_Y)
        else $error("x product not followed by y product");

endmodule

FILE: hdl/dpp_datapath.sv
// dpp_datapath: pixel counters, depth decode, shared coordinate multiplier, output register
// depends on dpp_pkg; driven by dpp_ctrl
module dpp_datapath
    import dpp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dpp_cfg_t                   cfg,
    input  dpp_cmd_t                   cmd,
    output dpp_status_t                sts,
    input  logic [PIX_W-1:0]           depth_low,
    input  logic [PIX_W-1:0]           depth_high,
    input  logic [PIX_W-1:0]           red_in,
    input  logic [PIX_W-1:0]           green_in,
    input  logic [PIX_W-1:0]           blue_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [COORD_W-1:0]  x_pos,
    output logic signed [COORD_W-1:0]  y_pos,
    output logic [Z_W-1:0]             z_depth,
    output logic [PIX_W-1:0]           red_out,
    output logic [PIX_W-1:0]           green_out,
    output logic [PIX_W-1:0]           blue_out
);

    logic [SIDE_W-1:0]         col_reg;
    logic [SIDE_W-1:0]         col_next;
    logic [SIDE_W-1:0]         row_reg;
    logic [SIDE_W-1:0]         row_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;

    logic [Z_W-1:0]            z_reg;
    logic signed [NC_W-1:0]    ncx_reg;
    logic signed [NC_W-1:0]    ncy_reg;
    logic [PIX_W-1:0]          red_reg;
    logic [PIX_W-1:0]          green_reg;
    logic [PIX_W-1:0]          blue_reg;
    logic [ZS_W-1:0]           zs_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [COORD_W-1:0] x_reg;

    logic [Z_W-1:0]            z_in;
    logic signed [NC_W-1:0]    ncx_in;
    logic signed [NC_W-1:0]    ncy_in;
    logic signed [NC_W-1:0]    mul_a;
    logic signed [PROD_W-1:0]  prod_comb;
    logic                      col_wrap;
    logic                      row_wrap;

    // z = low + (index - 1) * 256 + offset
    assign z_in = Z_W'({depth_high - PIX_W'(1), depth_low}) + Z_OFFSET;

    // negated centred coordinates: half - count
    assign ncx_in = $signed({2'b00, cfg.width[SIZE_W-1:1]}) - $signed({2'b00, col_reg});
    assign ncy_in = $signed({2'b00, cfg.height[SIZE_W-1:1]}) - $signed({2'b00, row_reg});

    assign col_wrap = ({1'b0, col_reg} + SIZE_W'(1)) >= cfg.width;
    assign row_wrap = ({1'b0, row_reg} + SIZE_W'(1)) >= cfg.height;

    assign sts.keep     = (depth_high != '0) && ((red_in | green_in | blue_in) != '0);
    assign sts.out_full = out_valid_reg && out_stall;

    assign mul_a     = cmd.mul_y ? ncy_reg : ncx_reg;
    assign prod_comb = PROD_W'(mul_a) * PROD_W'($signed({1'b0, zs_reg}));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + SIDE_W'(1);
            end
            else
            begin
                col_next = col_reg + SIDE_W'(1);
            end
        end
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            z_reg     <= z_in;
            ncx_reg   <= ncx_in;
            ncy_reg   <= ncy_in;
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
        end
        if (cmd.mul_zs)
            zs_reg <= ZS_W'(z_reg) * ZS_W'(cfg.scale);
        if (cmd.mul_x || cmd.mul_y)
            prod_reg <= prod_comb;
        if (cmd.mul_y)
            x_reg <= sat_coord(prod_reg);
        if (cmd.load_out)
        begin
            x_pos     <= x_reg;
            y_pos     <= sat_coord(prod_reg);
            z_depth   <= z_reg;
            red_out   <= red_reg;
            green_out <= green_reg;
            blue_out  <= blue_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_z_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> z_depth >= Z_OFFSET)
        else $error("emitted depth below offset");

endmodule

FILE: hdl/depth_pixel_to_point.sv
// depth_pixel_to_point: back-projects raster depth pixels to colored 3-D points
// a kept pixel steps through ST_ZS (z*scale multiply), ST_X and ST_Y (two passes
// through the shared coordinate multiplier) and ST_FIN, held while the output stalls
// a dropped pixel (index 0 or black) gives no word; only ST_IDLE accepts a pixel
// reset: counters at column 0 row 0, size 512x424, scale 30702, no word pending
// depends on dpp_pkg, dpp_ctrl, dpp_datapath
module depth_pixel_to_point
    import dpp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [PIX_W-1:0]           depth_low,
    input  logic [PIX_W-1:0]           depth_high,
    input  logic [PIX_W-1:0]           red_in,
    input  logic [PIX_W-1:0]           green_in,
    input  logic [PIX_W-1:0]           blue_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [COORD_W-1:0]  x_pos,
    output logic signed [COORD_W-1:0]  y_pos,
    output logic [Z_W-1:0]             z_depth,
    output logic [PIX_W-1:0]           red_out,
    output logic [PIX_W-1:0]           green_out,
    output logic [PIX_W-1:0]           blue_out
);

    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [SCALE_W-1:0] scale_reg;
    dpp_cfg_t           cfg;
    dpp_cmd_t           cmd;
    dpp_status_t        sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            scale_reg  <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                REG_SCALE_Q24:    scale_reg  <= cfg_data[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.width  = eff_size(width_reg);
    assign cfg.height = eff_size(height_reg);
    assign cfg.scale  = scale_reg;

    dpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    dpp_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sts        (sts),
        .depth_low  (depth_low),
        .depth_high (depth_high),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .x_pos      (x_pos),
        .y_pos      (y_pos),
        .z_depth    (z_depth),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out)
    );

endmodule
